/* rtl/hrn_pkg.sv */
`default_nettype none

package hrn_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam int ALPHA_W  = 16;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int ROW_W    = HEIGHT_W + 1;
  localparam int GRAD_W   = 16;
  localparam int CROSS_W  = 17;
  localparam int RESP_W   = 32;

  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd3932;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic col0;
    logic top_ok;
    logic mid_ok;
    logic emit;
    logic frame_end;
  } item_flags_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_PEAK
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/hrn_queue.sv */
`default_nettype none

module hrn_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DATA_W-1:0] in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_data
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] slots [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign in_ready  = (count != (ADDR_W + 1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + ADDR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + ADDR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (ADDR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (ADDR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/hrn_front.sv */
`default_nettype none

module hrn_front #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hrn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hrn_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_cmd,
  input  wire logic [hrn_pkg::GRAD_W-1:0]      in_gx2,
  input  wire logic [hrn_pkg::GRAD_W-1:0]      in_gy2,
  input  wire logic [hrn_pkg::CROSS_W-1:0]     in_gxgy,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output logic [hrn_pkg::RESP_W-1:0]           push_resp,
  output logic [COL_W-1:0]                     push_col,
  output hrn_pkg::item_flags_t                 push_flags
);

  import hrn_pkg::*;

  localparam int EW = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1) : WIDTH_W;

  logic [ALPHA_W-1:0]  alpha_q16;
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;

  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;

  logic [EW-1:0]    eff_w;
  logic [EW-1:0]    col_inc;
  logic [ROW_W-1:0] eff_h;
  logic [ROW_W-1:0] last_row;
  logic             in_frame;
  logic             ignore;
  logic             accept;
  logic             take;
  logic             advance;
  item_flags_t      flags;

  logic                 s1_valid, s2_valid, s3_valid;
  logic                 s1_zero, s2_zero, s3_zero;
  item_flags_t          s1_flags, s2_flags, s3_flags;
  logic [COL_W-1:0]     s1_col, s2_col, s3_col;
  logic [GRAD_W-1:0]    s1_a, s1_b;
  logic [CROSS_W-1:0]   s1_mag;
  logic [GRAD_W:0]      s1_tr;
  logic [31:0]          s2_det1, s3_det1;
  logic [33:0]          s2_det2, s3_det2;
  logic [33:0]          s2_tr2;
  logic [33:0]          s3_pen;
  logic [49:0]          pen_full;
  logic signed [35:0]   diff;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = EW'(1);
    end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(frame_width);
    end
    eff_h    = (frame_height == '0) ? ROW_W'(1) : {1'b0, frame_height};
    last_row = eff_h + ROW_W'(1);
    col_inc  = EW'(in_column) + EW'(1);
    in_frame = (in_row < eff_h);
    ignore   = (in_cmd == CMD_FLUSH) && in_frame;

    flags.col0      = (in_column == '0);
    flags.top_ok    = (in_row >= ROW_W'(2));
    flags.mid_ok    = (in_row >= ROW_W'(1)) && (in_row <= eff_h);
    flags.emit      = flags.col0 ? flags.top_ok : flags.mid_ok;
    flags.frame_end = flags.col0 && (in_row == last_row);
  end

  assign advance  = !s3_valid || push_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;
  assign take     = accept && !ignore;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q16    <= ALPHA_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      in_column    <= '0;
      in_row       <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ALPHA) begin
        alpha_q16 <= cfg_data[ALPHA_W-1:0];
      end
      if (cfg_index == REG_WIDTH) begin
        frame_width <= cfg_data[WIDTH_W-1:0];
        in_column   <= '0;
        in_row      <= '0;
      end
      if (cfg_index == REG_HEIGHT) begin
        frame_height <= cfg_data[HEIGHT_W-1:0];
        in_column    <= '0;
        in_row       <= '0;
      end
    end else if (take) begin
      if (in_row >= last_row) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (col_inc >= eff_w) begin
        in_column <= '0;
        in_row    <= in_row + ROW_W'(1);
      end else begin
        in_column <= col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  assign pen_full = 50'(alpha_q16) * 50'(s2_tr2);

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_zero  <= !in_frame;
      s1_flags <= flags;
      s1_col   <= in_column;
      s1_a     <= in_gx2;
      s1_b     <= in_gy2;
      s1_mag   <= in_gxgy[CROSS_W-1] ? CROSS_W'(-in_gxgy) : in_gxgy;
      s1_tr    <= {1'b0, in_gx2} + {1'b0, in_gy2};

      s2_zero  <= s1_zero;
      s2_flags <= s1_flags;
      s2_col   <= s1_col;
      s2_det1  <= 32'(s1_a) * 32'(s1_b);
      s2_det2  <= 34'(s1_mag) * 34'(s1_mag);
      s2_tr2   <= 34'(s1_tr) * 34'(s1_tr);

      s3_zero  <= s2_zero;
      s3_flags <= s2_flags;
      s3_col   <= s2_col;
      s3_det1  <= s2_det1;
      s3_det2  <= s2_det2;
      s3_pen   <= pen_full[49:16];
    end
  end

  assign diff = $signed({4'b0, s3_det1}) - $signed({2'b0, s3_det2})
              - $signed({2'b0, s3_pen});

  assign push_valid = s3_valid;
  assign push_col   = s3_col;
  assign push_flags = s3_flags;
  assign push_resp  = (s3_zero || diff[35] || diff == '0) ? '0 : diff[31:0];

endmodule

`default_nettype wire

/* rtl/hrn_back.sv */
`default_nettype none

module hrn_back #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [hrn_pkg::RESP_W-1:0]   in_resp,
  input  wire logic [COL_W-1:0]             in_col,
  input  wire hrn_pkg::item_flags_t         in_flags,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [hrn_pkg::RESP_W-1:0]        out_peak,
  output logic                              out_last
);

  import hrn_pkg::*;

  function automatic logic [RESP_W-1:0] max3(input logic [RESP_W-1:0] a,
                                             input logic [RESP_W-1:0] b,
                                             input logic [RESP_W-1:0] c);
    logic [RESP_W-1:0] m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  back_state_t state, state_next;

  logic [RESP_W-1:0] line_older [MAX_WIDTH];
  logic [RESP_W-1:0] line_newer [MAX_WIDTH];
  logic [RESP_W-1:0] older_rd;
  logic [RESP_W-1:0] newer_rd;

  logic [RESP_W-1:0] resp;
  logic [COL_W-1:0]  col;
  item_flags_t       flags;

  logic [RESP_W-1:0] win_mid [3];
  logic [RESP_W-1:0] win_right [3];
  logic [RESP_W-1:0] colmax [3];
  logic [RESP_W-1:0] centre;
  logic [RESP_W-1:0] top;
  logic [RESP_W-1:0] mid;
  logic [RESP_W-1:0] wmax;
  logic              out_free;
  logic              load_out;

  assign top      = flags.top_ok ? older_rd : '0;
  assign mid      = flags.mid_ok ? newer_rd : '0;
  assign wmax     = max3(colmax[0], colmax[1], colmax[2]);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = BK_LOAD;
        end
      end
      BK_LOAD: begin
        state_next = BK_PEAK;
      end
      BK_PEAK: begin
        if (!flags.emit) begin
          state_next = BK_IDLE;
        end else if (out_free) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && in_valid) begin
      older_rd <= line_older[in_col];
      newer_rd <= line_newer[in_col];
    end
    if (state == BK_LOAD) begin
      line_older[col] <= newer_rd;
      line_newer[col] <= resp;
    end
  end

  // The candidate window is the old middle and right columns plus the new
  // column, whose place is taken by zeros when the row has just wrapped.
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && in_valid) begin
      resp  <= in_resp;
      col   <= in_col;
      flags <= in_flags;
    end
    if (state == BK_LOAD) begin
      colmax[0] <= max3(win_mid[0], win_mid[1], win_mid[2]);
      colmax[1] <= max3(win_right[0], win_right[1], win_right[2]);
      colmax[2] <= flags.col0 ? '0 : max3(top, mid, resp);
      centre    <= win_right[1];
      for (int k = 0; k < 3; k++) begin
        win_mid[k] <= flags.col0 ? '0 : win_right[k];
      end
      win_right[0] <= top;
      win_right[1] <= mid;
      win_right[2] <= resp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_peak <= (centre == wmax) ? centre : '0;
      out_last <= flags.frame_end;
    end
  end

endmodule

`default_nettype wire

/* rtl/harris_response_nms_top.sv */
`default_nettype none

// Channel   Signals                           Contents
// s_axis    tvalid tready tdata tuser         one pixel or flush item
// m_axis    tvalid tready tdata tlast         one suppressed response
// cfg       cfg_we cfg_index cfg_data         register writes, no read-back
//
// The front takes one item a cycle unless a full queue holds its last stage,
// and computes the response in three pipelined stages; an ignored flush is
// accepted but goes no further. The back takes each item through a line store
// read, a window update and a window maximum before it takes the next.
// Reset clears control state only; the line stores start unwritten.
// A four-entry queue parts front and back, and the output register lets the
// back read and update the window for the next item while a result waits.

module harris_response_nms_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hrn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hrn_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sum_gx2 [15:0], sum_gy2 [31:16], sum_gxgy [48:32], zero padding above
  input  wire logic [55:0]                     s_axis_tdata,
  // cmd
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // peak_response [31:0]
  output logic [31:0]                          m_axis_tdata,
  output logic                                 m_axis_tlast
);

  import hrn_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int FLAGS_W = $bits(item_flags_t);
  localparam int Q_W     = RESP_W + COL_W + FLAGS_W;
  localparam int Q_DEPTH = 4;

  logic              push_valid;
  logic              push_ready;
  logic [RESP_W-1:0] push_resp;
  logic [COL_W-1:0]  push_col;
  item_flags_t       push_flags;
  logic [Q_W-1:0]    push_data;

  logic              pop_valid;
  logic              pop_ready;
  logic [Q_W-1:0]    pop_data;
  item_flags_t       pop_flags;

  hrn_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser),
    .in_gx2     (s_axis_tdata[15:0]),
    .in_gy2     (s_axis_tdata[31:16]),
    .in_gxgy    (s_axis_tdata[48:32]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_resp  (push_resp),
    .push_col   (push_col),
    .push_flags (push_flags)
  );

  assign push_data = {push_flags, push_col, push_resp};
  assign pop_flags = item_flags_t'(pop_data[Q_W-1 -: FLAGS_W]);

  hrn_queue #(
    .DATA_W (Q_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  hrn_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop_valid),
    .in_ready  (pop_ready),
    .in_resp   (pop_data[RESP_W-1:0]),
    .in_col    (pop_data[RESP_W +: COL_W]),
    .in_flags  (pop_flags),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_peak  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* tb/sv/hrn_peak_checker.sv */
`timescale 1ns / 100ps

module hrn_peak_checker
  import hrn_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [55:0]           s_axis_tdata,
  input  wire logic                  s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [31:0]           m_axis_tdata,
  input  wire logic                  m_axis_tlast,
  output int                         fail_count,
  output int                         pending,
  output int                         result_count,
  output int                         peak_count,
  output int                         frame_ends
);

  typedef struct packed {
    logic [RESP_W-1:0] peak;
    logic              frame_end;
  } peak_item_t;

  peak_item_t due_peaks[$];

  logic [ALPHA_W-1:0]  alpha_q16;
  logic [WIDTH_W-1:0]  frame_w;
  logic [HEIGHT_W-1:0] frame_h;

  logic [RESP_W-1:0]      line_older [MAX_WIDTH];
  logic [RESP_W-1:0]      line_newer [MAX_WIDTH];
  logic [8:0][RESP_W-1:0] window;
  int unsigned            in_col;
  int unsigned            in_row;

  int errs;
  int n_results;
  int n_peaks;
  int n_ends;

  function automatic int unsigned eff_width();
    if (frame_w == '0) return 1;
    if (frame_w > MAX_WIDTH) return MAX_WIDTH;
    return frame_w;
  endfunction

  function automatic int unsigned eff_height();
    return (frame_h == '0) ? 1 : frame_h;
  endfunction

  function automatic logic [RESP_W-1:0] harris_resp(logic [GRAD_W-1:0] gx2,
                                                    logic [GRAD_W-1:0] gy2,
                                                    logic [CROSS_W-1:0] gxgy);
    logic [63:0] mag;
    logic [63:0] det;
    logic [63:0] tr;
    logic [63:0] sub;
    mag = gxgy[CROSS_W-1] ? (64'h20000 - 64'(gxgy)) : 64'(gxgy);
    det = 64'(gx2) * 64'(gy2);
    tr  = 64'(gx2) + 64'(gy2);
    sub = mag * mag + ((64'(alpha_q16) * tr * tr) >> 16);
    return (det <= sub) ? '0 : RESP_W'(det - sub);
  endfunction

  function automatic logic [RESP_W-1:0] nms_peak(logic [8:0][RESP_W-1:0] w);
    logic [RESP_W-1:0] m;
    m = '0;
    for (int k = 0; k < 9; k++) begin
      if (w[k] > m) m = w[k];
    end
    return (w[4] == m) ? w[4] : '0;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    window = '0;
  endfunction

  task automatic advance_pixel(logic cmd, logic [GRAD_W-1:0] gx2, logic [GRAD_W-1:0] gy2,
                               logic [CROSS_W-1:0] gxgy);
    int unsigned            wd;
    int unsigned            ht;
    int unsigned            col;
    int unsigned            ro;
    int unsigned            co;
    logic [RESP_W-1:0]      v;
    logic [RESP_W-1:0]      top;
    logic [RESP_W-1:0]      mid;
    logic [RESP_W-1:0]      pk;
    logic [8:0][RESP_W-1:0] edge_win;
    logic                   hit;
    wd  = eff_width();
    ht  = eff_height();
    hit = 1'b0;
    pk  = '0;
    ro  = 0;
    co  = 0;
    // A flush while pixels of the frame are still due changes nothing.
    if (!(cmd == CMD_FLUSH && in_row < ht)) begin
      v   = (in_row < ht) ? harris_resp(gx2, gy2, gxgy) : '0;
      col = (in_col < wd) ? in_col : 0;
      top = (in_row >= 2) ? line_older[col] : '0;
      mid = (in_row >= 1 && in_row - 1 < ht) ? line_newer[col] : '0;
      line_older[col] = line_newer[col];
      line_newer[col] = v;
      if (col == 0) begin
        // The last column of the previous row has no right-hand neighbours.
        for (int k = 0; k < 3; k++) begin
          edge_win[k * 3]     = window[k * 3 + 1];
          edge_win[k * 3 + 1] = window[k * 3 + 2];
          edge_win[k * 3 + 2] = '0;
        end
        if (in_row >= 2) begin
          hit = 1'b1;
          ro  = in_row - 2;
          co  = wd - 1;
          pk  = nms_peak(edge_win);
        end
        for (int k = 0; k < 3; k++) begin
          window[k * 3]     = '0;
          window[k * 3 + 1] = '0;
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          window[k * 3]     = window[k * 3 + 1];
          window[k * 3 + 1] = window[k * 3 + 2];
        end
      end
      window[2] = top;
      window[5] = mid;
      window[8] = v;
      if (col != 0 && in_row >= 1 && in_row - 1 < ht) begin
        hit = 1'b1;
        ro  = in_row - 1;
        co  = col - 1;
        pk  = nms_peak(window);
      end
      if (in_row >= ht + 1) begin
        restart_frame();
      end else begin
        in_col = col + 1;
        if (in_col >= wd) begin
          in_col = 0;
          in_row++;
        end
      end
      if (hit) due_peaks.push_back('{pk, (ro == ht - 1 && co == wd - 1)});
    end
  endtask

  always @(posedge clk) begin
    peak_item_t exp_item;
    if (rst) begin
      alpha_q16 = ALPHA_RESET;
      frame_w   = WIDTH_RESET;
      frame_h   = HEIGHT_RESET;
      for (int k = 0; k < MAX_WIDTH; k++) begin
        line_older[k] = '0;
        line_newer[k] = '0;
      end
      restart_frame();
      due_peaks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALPHA: begin
            alpha_q16 = cfg_data[ALPHA_W-1:0];
          end
          REG_WIDTH: begin
            frame_w = cfg_data[WIDTH_W-1:0];
            restart_frame();
          end
          REG_HEIGHT: begin
            frame_h = cfg_data[HEIGHT_W-1:0];
            restart_frame();
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_pixel(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                      s_axis_tdata[48:32]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (m_axis_tdata != '0) n_peaks++;
        if (m_axis_tlast) n_ends++;
        if (due_peaks.size() == 0) begin
          $error("unexpected result: peak_response %0d, frame_end %0b",
                 m_axis_tdata, m_axis_tlast);
          errs++;
        end else begin
          exp_item = due_peaks.pop_front();
          if (m_axis_tdata !== exp_item.peak) begin
            $error("peak_response: expected %0d, actual %0d", exp_item.peak, m_axis_tdata);
            errs++;
          end
          if (m_axis_tlast !== exp_item.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", exp_item.frame_end, m_axis_tlast);
            errs++;
          end
        end
      end
    end
    pending      <= due_peaks.size();
    fail_count   <= errs;
    result_count <= n_results;
    peak_count   <= n_peaks;
    frame_ends   <= n_ends;
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import hrn_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int IDLE_WAIT    = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 850;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic [CROSS_W-1:0] gxgy;
    logic [GRAD_W-1:0]  gy2;
    logic [GRAD_W-1:0]  gx2;
  } tensor_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [55:0]           s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tlast;

  int fail_count;
  int pending;
  int result_count;
  int peak_count;
  int frame_ends;

  logic    hold_off_go = 1'b0;
  bit      sender_calm;
  tensor_t last_px;
  int      items_sent;
  int      directed_sent;
  int      geometries;

  always #6 clk = ~clk;

  harris_response_nms_top #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  hrn_peak_checker #(
    .MAX_WIDTH(MAX_W)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .peak_count   (peak_count),
    .frame_ends   (frame_ends)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ALPHA_RESET;
      3: return ALPHA_W'($urandom);
      default: return ALPHA_W'($urandom_range(0, 12000));
    endcase
  endfunction

  function automatic tensor_t next_pixel();
    tensor_t     px;
    int unsigned mag;
    case ($urandom_range(0, 7))
      0: px = '0;
      1: px = last_px;
      default: begin
        px.gx2 = GRAD_W'($urandom);
        px.gy2 = GRAD_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          do px.gxgy = CROSS_W'($urandom); while (px.gxgy == 17'h10000);
        end else begin
          mag     = $urandom_range(0, 4095);
          px.gxgy = $urandom_range(0, 1) ? CROSS_W'(-mag) : CROSS_W'(mag);
        end
      end
    endcase
    last_px = px;
    return px;
  endfunction

  task automatic send_item(logic cmd, tensor_t px);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, px.gxgy, px.gy2, px.gx2};
    do @(posedge clk); while (!s_axis_tready);
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pixel(logic [GRAD_W-1:0] gx2, logic [GRAD_W-1:0] gy2,
                       logic [CROSS_W-1:0] gxgy);
    send_item(CMD_PIXEL, '{gxgy, gy2, gx2});
    directed_sent++;
  endtask

  task automatic flush_item();
    send_item(CMD_FLUSH, tensor_t'({$urandom, $urandom}));
    directed_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] wv, logic [CFG_DATA_W-1:0] hv,
                           logic [ALPHA_W-1:0] alpha);
    wait_idle();
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    geometries++;
  endtask

  // Pixels with stray flushes mixed in, then the drain with some pixels
  // standing in for flushes. A frame may be cut short; the next geometry
  // write restarts it.
  task automatic run_frame(int unsigned w, int unsigned h, bit may_abort);
    int unsigned n_px;
    int unsigned stop_at;
    int unsigned alpha_at;
    tensor_t     px;
    n_px     = w * h;
    stop_at  = (may_abort && $urandom_range(0, 7) == 0) ? $urandom_range(0, n_px - 1) : n_px;
    alpha_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n_px) : n_px + 1;
    for (int unsigned k = 0; k < n_px; k++) begin
      if (k == stop_at) begin
        wait_idle();
        return;
      end
      if (k == alpha_at) begin
        wait_idle();
        write_reg(REG_ALPHA, pick_alpha());
      end
      if ($urandom_range(0, 19) == 0) send_item(CMD_FLUSH, next_pixel());
      px = next_pixel();
      send_item(CMD_PIXEL, px);
      items_sent++;
    end
    for (int unsigned k = 0; k <= w; k++) begin
      px = next_pixel();
      send_item(($urandom_range(0, 6) == 0) ? CMD_PIXEL : CMD_FLUSH, px);
      items_sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned           w;
    int unsigned           h;
    logic [CFG_DATA_W-1:0] wv;
    logic [CFG_DATA_W-1:0] hv;
    tensor_t               px;
    last_px     = '0;
    sender_calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes with no sensitivity penalty, an ignored flush mid-frame
    // and a pixel standing in for a flush during the drain.
    write_reg(REG_ALPHA, '0);
    write_reg(REG_WIDTH, 16'd3);
    write_reg(REG_HEIGHT, 16'd2);
    pixel(16'hFFFF, 16'hFFFF, 17'd0);
    pixel(16'd0, 16'd0, 17'd0);
    pixel(16'hFFFF, 16'd0, 17'd65535);
    flush_item();
    pixel(16'hFFFF, 16'hFFFF, CROSS_W'(-65535));
    pixel(16'd1, 16'd1, 17'd0);
    pixel(16'hFFFF, 16'hFFFF, 17'd0);
    flush_item();
    pixel(16'd12345, 16'd321, 17'd7);
    flush_item();
    flush_item();

    // Zero width and height both count as one.
    set_frame('0, '0, '1);
    pixel(16'd40000, 16'd100, 17'd5);
    flush_item();
    flush_item();

    // Equal responses side by side are all kept.
    set_frame(16'd3, 16'd1, ALPHA_RESET);
    pixel(16'd1000, 16'd1000, 17'd10);
    pixel(16'd1000, 16'd1000, 17'd10);
    pixel(16'd1000, 16'd1000, 17'd10);
    repeat (4) flush_item();

    // The receiver holds off during this frame so that the input stalls.
    set_frame(16'd16, 16'd10, ALPHA_RESET);
    sender_calm = 1'b1;
    hold_off_go <= 1'b1;
    run_frame(16, 10, 1'b0);

    while (items_sent < RAND_ITEMS) begin
      w  = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h  = $urandom_range(1, 8);
      wv = CFG_DATA_W'(w);
      hv = CFG_DATA_W'(h);
      if (w == 1 && $urandom_range(0, 1) == 1) begin
        wv = '0;
      end else if ($urandom_range(0, 3) == 0) begin
        wv[15:11] = 5'($urandom);
      end
      if (h == 1 && $urandom_range(0, 1) == 1) hv = '0;
      set_frame(wv, hv, pick_alpha());
      sender_calm = ($urandom_range(0, 3) == 0);
      run_frame(w, h, 1'b1);
    end

    // A width above the line store size, with the frame cut short.
    set_frame(16'd2047, 16'd1, pick_alpha());
    sender_calm = 1'b1;
    repeat (20) begin
      px = next_pixel();
      send_item(CMD_PIXEL, px);
      items_sent++;
    end

    // Tallest frame, left unfinished.
    set_frame(16'd1, 16'hFFFF, pick_alpha());
    sender_calm = 1'b0;
    repeat (40) begin
      px = next_pixel();
      send_item(CMD_PIXEL, px);
      items_sent++;
    end

    wait_idle();
    @(negedge clk);
    $display("Run covered %0d random and %0d directed items over %0d geometry settings.",
             items_sent, directed_sent, geometries);
    $display("%0d results checked, %0d local maxima, %0d frame ends, %0d mismatches.",
             result_count, peak_count, frame_ends, fail_count);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned gap;
    int unsigned stretch;
    bit          calm;
    bit          held;
    held    = 1'b0;
    calm    = 1'b0;
    stretch = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stretch == 0) begin
        calm    = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(10, 60);
      end
      stretch--;
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 12);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/hrn_pkg.sv
rtl/hrn_queue.sv
rtl/hrn_front.sv
rtl/hrn_back.sv
rtl/harris_response_nms_top.sv
tb/sv/hrn_peak_checker.sv
tb/sv/tb_top.sv
